// ===== src/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared sizes, codes and memory request types of the paged sparse array.
// ----------------------------------------------------------------------------
package psa_pkg;

   // Geometry
   localparam int ELEMS_PER_PAGE = 512;
   localparam int NUM_PAGES      = 4096;

   // Transaction field widths
   localparam int INDEX_W = 24;
   localparam int VALUE_W = 64;

   // Index split: {depth, slot, offset}
   localparam int OFFSET_W = $clog2(ELEMS_PER_PAGE);
   localparam int SLOT_W   = OFFSET_W;
   localparam int DEPTH_W  = INDEX_W - OFFSET_W - SLOT_W;
   localparam int NEED_W   = DEPTH_W + 1;

   // Page pointers and the bump allocator
   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int FREE_W = PAGE_W + 1;

   // Link memory: page links first, directory entries above them
   localparam int LINK_DEPTH = NUM_PAGES + ELEMS_PER_PAGE;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   // Word memory
   localparam int WORD_DEPTH = NUM_PAGES * ELEMS_PER_PAGE;
   localparam int WORD_AW    = PAGE_W + OFFSET_W;

   // Operation and status codes
   typedef enum logic {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_DONE = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   // Memory request bundles
   typedef struct packed {
      logic               we;
      logic [LINK_AW-1:0] addr;
      logic [PAGE_W-1:0]  wdata;
   } link_req_type;

   typedef struct packed {
      logic               we;
      logic [WORD_AW-1:0] addr;
      logic [VALUE_W-1:0] wdata;
   } word_req_type;

endpackage

// ===== src/psa_req_if.sv =====
// ----------------------------------------------------------------------------
// psa_req_if
// Request channel: one get or put transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_req_if import psa_pkg::*; ();

   logic               valid;
   logic               ready;
   logic               func;
   logic [INDEX_W-1:0] index;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);

endinterface

// ===== src/psa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psa_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface psa_rsp_if import psa_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] read_value;
   logic               status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);

endinterface

// ===== src/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write first-come, read returns old contents
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/psa_ctrl.sv =====
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: clears both memories after reset, walks the page chain one
// link per cycle, allocates missing pages and holds the response register.
// ----------------------------------------------------------------------------
module psa_ctrl import psa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   psa_req_if.sink            req_chan,
   psa_rsp_if.source          rsp_chan,
   output link_req_type       link_req,
   input  logic [PAGE_W-1:0]  link_rdata,
   output word_req_type       word_req,
   input  logic [VALUE_W-1:0] word_rdata
);

   localparam int CMP_W = (FREE_W > NEED_W) ? FREE_W : NEED_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_ALLOC,
      ST_WORD,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [WORD_AW-1:0]  clr_addr_ff, clr_addr_in;
   func_type            op_ff, op_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [NEED_W-1:0]   have_ff, have_in;
   logic [PAGE_W-1:0]   last_page_ff, last_page_in;
   logic [LINK_AW-1:0]  alloc_addr_ff, alloc_addr_in;
   logic [NEED_W-1:0]   remain_ff, remain_in;
   logic [FREE_W-1:0]   free_ff, free_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                rsp_free;
   logic                req_fire;
   logic [OFFSET_W-1:0] req_offset;
   logic [SLOT_W-1:0]   req_slot;
   logic [DEPTH_W-1:0]  req_depth;
   logic [NEED_W-1:0]   need;
   logic [FREE_W-1:0]   avail;

   // Handshake and index split
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_offset     = req_chan.index[OFFSET_W-1:0];
   assign req_slot       = req_chan.index[OFFSET_W +: SLOT_W];
   assign req_depth      = req_chan.index[INDEX_W-1 -: DEPTH_W];

   // Pages still missing on the path, and pages left in the pool
   assign need  = {1'b0, depth_ff} + NEED_W'(1) - have_ff;
   assign avail = FREE_W'(NUM_PAGES) - free_ff;

   // Next-state and memory request logic
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      offset_in     = offset_ff;
      slot_in       = slot_ff;
      depth_in      = depth_ff;
      value_in      = value_ff;
      have_in       = have_ff;
      last_page_in  = last_page_ff;
      alloc_addr_in = alloc_addr_ff;
      remain_in     = remain_ff;
      free_in       = free_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      link_req       = '0;
      link_req.addr  = LINK_AW'(last_page_ff);
      word_req       = '0;
      word_req.addr  = {last_page_ff, offset_ff};
      word_req.wdata = value_ff;

      unique case (state_ff)
         // Zero one word per cycle, and one link entry while the address is inside the link memory
         ST_CLEAR: begin
            link_req.we   = (clr_addr_ff < WORD_AW'(LINK_DEPTH));
            link_req.addr = clr_addr_ff[LINK_AW-1:0];
            word_req.we    = 1'b1;
            word_req.addr  = clr_addr_ff;
            word_req.wdata = '0;
            clr_addr_in    = clr_addr_ff + WORD_AW'(1);
            if (clr_addr_ff == WORD_AW'(WORD_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take a transaction and fetch its directory entry
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = func_type'(req_chan.func);
               offset_in     = req_offset;
               slot_in       = req_slot;
               depth_in      = req_depth;
               value_in      = req_chan.value;
               have_in       = '0;
               link_req.addr = LINK_AW'(NUM_PAGES) + LINK_AW'(req_slot);
               state_in      = ST_WALK;
            end
         end

         // One link per cycle; link_rdata is the pointer of chain position have_ff
         ST_WALK: begin
            if (link_rdata == '0) begin
               if (op_ff == FUNC_READ) begin
                  res_value_in  = '0;
                  res_status_in = STATUS_DONE;
                  state_in      = ST_FINISH;
               end else if (CMP_W'(need) > CMP_W'(avail)) begin
                  res_value_in  = '0;
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else begin
                  remain_in     = need;
                  alloc_addr_in = (have_ff == '0)
                                  ? LINK_AW'(NUM_PAGES) + LINK_AW'(slot_ff)
                                  : LINK_AW'(last_page_ff);
                  state_in      = ST_ALLOC;
               end
            end else begin
               have_in      = have_ff + NEED_W'(1);
               last_page_in = link_rdata;
               if (have_ff == {1'b0, depth_ff}) begin
                  word_req.addr = {link_rdata, offset_ff};
                  if (op_ff == FUNC_READ) begin
                     state_in = ST_WORD;
                  end else begin
                     word_req.we   = 1'b1;
                     res_value_in  = '0;
                     res_status_in = STATUS_DONE;
                     state_in      = ST_FINISH;
                  end
               end else begin
                  link_req.addr = LINK_AW'(link_rdata);
               end
            end
         end

         // Link one fresh page per cycle; store the word into the last one
         ST_ALLOC: begin
            link_req.we    = 1'b1;
            link_req.addr  = alloc_addr_ff;
            link_req.wdata = free_ff[PAGE_W-1:0];
            alloc_addr_in  = LINK_AW'(free_ff[PAGE_W-1:0]);
            free_in        = free_ff + FREE_W'(1);
            remain_in      = remain_ff - NEED_W'(1);
            if (remain_ff == NEED_W'(1)) begin
               word_req.we   = 1'b1;
               word_req.addr = {free_ff[PAGE_W-1:0], offset_ff};
               res_value_in  = '0;
               res_status_in = STATUS_DONE;
               state_in      = ST_FINISH;
            end
         end

         // Word read data returns
         ST_WORD: begin
            res_value_in  = word_rdata;
            res_status_in = STATUS_DONE;
            state_in      = ST_FINISH;
         end

         // Hand the result to the output register once it has room
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         free_ff      <= FREE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      offset_ff     <= offset_in;
      slot_ff       <= slot_in;
      depth_ff      <= depth_in;
      value_ff      <= value_in;
      have_ff       <= have_in;
      last_page_ff  <= last_page_in;
      alloc_addr_ff <= alloc_addr_in;
      remain_ff     <= remain_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // Checks
   a_free_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (free_ff >= $past(free_ff)))
      else $error("free page counter moved backward");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(NUM_PAGES))
      else $error("free page counter past the pool");

   a_no_null_link: assert property (@(posedge clock) disable iff (reset)
      (link_req.we && state_ff != ST_CLEAR) |-> (link_req.addr != '0))
      else $error("link written for the null page");

   a_full_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && res_status_ff == STATUS_FULL) |-> (op_ff == FUNC_WRITE))
      else $error("full status on a read");

endmodule

// ===== src/paged_sparse_array.sv =====
// ----------------------------------------------------------------------------
// paged_sparse_array
// Demand-allocated sparse array of 64-bit words, pages chained per slot.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one transaction per valid/ready handshake: func (0 get,
//  1 put), a 24-bit index and the 64-bit value for a put. rsp_chan returns
//  exactly one transaction per request, in order: read_value (0 for a put or
//  for a missing page) and status (1 when a put finds too few free pages;
//  nothing is changed then).
//  The index is split into offset (low 9 bits), directory slot (next 9 bits)
//  and chain depth d (top 6 bits). A single-port link memory holds the
//  directory and all page links and serves one read or write per cycle, so
//  a request walks its chain one link at a time. A get that finds its page
//  then reads the word; a put over d + 1 existing pages writes its word as
//  the last link arrives. A request that meets a missing page after h
//  existing ones stops there; a put then links n new pages, one at a time
//  (n = 0 when it is refused). A new request is taken only once the
//  previous response is loaded into the output register.
//  After reset both memories are cleared one word per cycle while
//  req_chan.ready stays low.
//  A stalled rsp_chan holds its transaction; the block keeps working on the
//  next request and waits only when a second result is ready.
// ----------------------------------------------------------------------------
module paged_sparse_array import psa_pkg::*; (
   input logic       clock,
   input logic       reset,
   psa_req_if.sink   req_chan,
   psa_rsp_if.source rsp_chan
);

   link_req_type       link_req;
   word_req_type       word_req;
   logic [PAGE_W-1:0]  link_rdata;
   logic [VALUE_W-1:0] word_rdata;

   // Sequencer
   psa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .link_req   (link_req),
      .link_rdata (link_rdata),
      .word_req   (word_req),
      .word_rdata (word_rdata)
   );

   // Directory and page links
   psa_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (link_req.we),
      .addr  (link_req.addr),
      .wdata (link_req.wdata),
      .rdata (link_rdata)
   );

   // Page contents
   psa_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WORD_DEPTH)
   ) u_word_ram (
      .clock (clock),
      .we    (word_req.we),
      .addr  (word_req.addr),
      .wdata (word_req.wdata),
      .rdata (word_rdata)
   );

endmodule
